// ===== hdl/parallel_disk_block_read_host_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the parallel disk block read host
// Clocked, reset-qualified implication checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_DISK_BLOCK_READ_HOST_ASSERT_SVH
`define PARALLEL_DISK_BLOCK_READ_HOST_ASSERT_SVH

// Same-cycle implication.
`define PDBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PDBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pdbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdbr_pkg
// Shared types and constants of the parallel disk block read host.
// ----------------------------------------------------------------------------
package pdbr_pkg;

    localparam int BLOCK_BYTES = 536;
    localparam int BC_W        = $clog2(BLOCK_BYTES + 1);
    localparam logic [BC_W-1:0] BLOCK_BYTES_C = BC_W'(BLOCK_BYTES);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_HANDSHAKE  = 2'd1;
    localparam logic [1:0] ERR_SECOND_ACK = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_SETUP_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_HOLD_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_COUNT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_THRESHOLD = 3'd5;

    typedef struct packed {
        logic        command;
        logic [15:0] block_address;
        logic        busy_level;
        logic [7:0]  bus_data;
        logic        bus_parity;
    } t_req;

    typedef struct packed {
        logic       cmd_line;
        logic       strobe_line;
        logic       dir_read;
        logic [7:0] bus_out;
        logic       parity_out;
        logic       char_valid;
        logic [6:0] low_char;
        logic [6:0] high_char;
        logic       last_char;
        logic [1:0] error_code;
        logic       active;
    } t_rsp;

    // Byte with its odd parity bit on top.
    function automatic logic [8:0] odd_frame(input logic [7:0] data);
        return {~^data, data};
    endfunction

endpackage

// ===== hdl/pdbr_req_if.sv =====
// ----------------------------------------------------------------------------
// pdbr_req_if
// Valid/ready channel that carries one tick or start request.
// ----------------------------------------------------------------------------
interface pdbr_req_if;
    logic           valid;
    logic           ready;
    pdbr_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/pdbr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pdbr_rsp_if
// Valid/ready channel that carries one line and character result.
// ----------------------------------------------------------------------------
interface pdbr_rsp_if;
    logic           valid;
    logic           ready;
    pdbr_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/parallel_disk_block_read_host.sv =====
// ----------------------------------------------------------------------------
// parallel_disk_block_read_host
// Host side sequencer of a strobed parallel disk block read, one tick per
// request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  i_req     in         command, block_address, busy_level, bus_data, bus_parity
//  o_rsp     out        line levels, data characters, error_code, active
//  i_cfg_*   in         register writes, index 0 to 5
//
//  One request is accepted per cycle while no result waits untaken in o_rsp;
//  its result is in the output register on the next cycle.
//  The sequencer state and the output register set the rate.
//  Reset is synchronous and brings all control lines high with the bus idle.
//  i_req.ready falls only while a result waits in o_rsp and is not taken.
// ----------------------------------------------------------------------------
`include "parallel_disk_block_read_host_assert.svh"

module parallel_disk_block_read_host (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pdbr_req_if.sink                            i_req,
    pdbr_rsp_if.source                          o_rsp,
    input  logic                                i_cfg_wr_en,
    input  logic [pdbr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdbr_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [24:0] {
        PH_IDLE      = 25'h0000001,
        PH_WAIT_HI1  = 25'h0000002,
        PH_D_SETUP   = 25'h0000004,
        PH_D_LOWER   = 25'h0000008,
        PH_D_WAITLO  = 25'h0000010,
        PH_WAIT_LO1  = 25'h0000020,
        PH_D_READ1   = 25'h0000040,
        PH_A1_LO     = 25'h0000080,
        PH_A1_HI     = 25'h0000100,
        PH_D_CMDHI   = 25'h0000200,
        PH_D_WAITHI2 = 25'h0000400,
        PH_WAIT_HI2  = 25'h0000800,
        PH_D_CMDS    = 25'h0001000,
        PH_C_SETUP   = 25'h0002000,
        PH_C_DRIVE   = 25'h0004000,
        PH_C_HOLD    = 25'h0008000,
        PH_D_POSTCMD = 25'h0010000,
        PH_D_RDBUS   = 25'h0020000,
        PH_D_CMDLO   = 25'h0040000,
        PH_WAIT_LO2  = 25'h0080000,
        PH_A2_LO     = 25'h0100000,
        PH_A2_HI     = 25'h0200000,
        PH_WAIT_HI3  = 25'h0400000,
        PH_D_LO      = 25'h0800000,
        PH_D_HI      = 25'h1000000
    } t_phase;

    localparam int PIN_CMD = 0;
    localparam int PIN_STB = 1;
    localparam int PIN_DIR = 2;
    localparam logic [11:0] PIN_RESET = 12'h807;

    localparam logic [8:0] ACK_FIRST  = 9'h001;
    localparam logic [8:0] ACK_READ   = 9'h002;
    localparam logic [7:0] ANSWER     = 8'h55;
    localparam logic [6:0] CHAR_BASE  = 7'h40;

    localparam logic [2:0] CI_ADDR_HI = 3'd2;
    localparam logic [2:0] CI_ADDR_LO = 3'd3;
    localparam logic [2:0] CI_RETRY   = 3'd4;
    localparam logic [2:0] CI_SPARE   = 3'd5;
    localparam logic [2:0] CMD_COUNT  = 3'd6;

    localparam int BC_W = pdbr_pkg::BC_W;

    logic [15:0] r_strobe_ticks;
    logic [15:0] r_cmd_setup_ticks;
    logic [15:0] r_cmd_hold_ticks;
    logic [15:0] r_settle_ticks;
    logic [7:0]  r_retry_count;
    logic [7:0]  r_spare_threshold;

    t_phase          r_phase, n_phase;
    logic [15:0]     r_wc, n_wc;
    logic [BC_W-1:0] r_bc, n_bc;
    logic [2:0]      r_ci, n_ci;
    logic [15:0]     r_addr, n_addr;
    logic [11:0]     r_pins, n_pins;

    logic           r_out_valid;
    pdbr_pkg::t_rsp r_out, n_out;

    logic           req_accept;
    pdbr_pkg::t_req req;
    logic [8:0]     sampled;

    logic           pins_odd;
    logic           bc_ok;
    logic           rsp_fault;
    logic           fault_ok;
    logic           rsp_char;
    logic           char_ok;
    logic           rsp_last;
    logic           last_ok;

    function automatic logic [7:0] f_command_byte(
        input logic [2:0]  idx,
        input logic [15:0] addr,
        input logic [7:0]  retry,
        input logic [7:0]  spare
    );
        logic [7:0] b;
        unique case (idx)
            CI_ADDR_HI: b = addr[15:8];
            CI_ADDR_LO: b = addr[7:0];
            CI_RETRY:   b = retry;
            CI_SPARE:   b = spare;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    assign req         = i_req.payload;
    assign sampled     = {req.bus_parity, req.bus_data};
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_accept  = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe_ticks    <= 16'd5;
            r_cmd_setup_ticks <= 16'd100;
            r_cmd_hold_ticks  <= 16'd1000;
            r_settle_ticks    <= 16'd2000;
            r_retry_count     <= 8'd100;
            r_spare_threshold <= 8'd20;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pdbr_pkg::CFG_STROBE_TICKS:    r_strobe_ticks    <= i_cfg_data;
                pdbr_pkg::CFG_CMD_SETUP_TICKS: r_cmd_setup_ticks <= i_cfg_data;
                pdbr_pkg::CFG_CMD_HOLD_TICKS:  r_cmd_hold_ticks  <= i_cfg_data;
                pdbr_pkg::CFG_SETTLE_TICKS:    r_settle_ticks    <= i_cfg_data;
                pdbr_pkg::CFG_RETRY_COUNT:     r_retry_count     <= i_cfg_data[7:0];
                pdbr_pkg::CFG_SPARE_THRESHOLD: r_spare_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The first case handles the busy waits and counts pauses down; the second
    // acts on the last tick of a pause, which may be the tick it was entered.
    always_comb begin
        n_phase = r_phase;
        n_wc    = r_wc;
        n_bc    = r_bc;
        n_ci    = r_ci;
        n_addr  = r_addr;
        n_pins  = r_pins;
        n_out   = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (req.command == pdbr_pkg::CMD_START) begin
                    n_addr  = req.block_address;
                    n_phase = PH_WAIT_HI1;
                    n_wc    = 16'd0;
                end
            end
            PH_WAIT_HI1: begin
                if (req.busy_level) begin
                    n_phase = PH_D_SETUP;
                    n_wc    = r_settle_ticks;
                end
            end
            PH_WAIT_LO1: begin
                if (!req.busy_level) begin
                    n_phase = PH_D_READ1;
                    n_wc    = r_settle_ticks;
                end
            end
            PH_WAIT_HI2: begin
                if (req.busy_level) begin
                    n_ci    = 3'd0;
                    n_phase = PH_D_CMDS;
                    n_wc    = r_settle_ticks;
                end
            end
            PH_WAIT_LO2: begin
                if (!req.busy_level) begin
                    n_pins[PIN_STB] = 1'b0;
                    if (sampled != ACK_READ) begin
                        n_pins           = PIN_RESET;
                        n_phase          = PH_IDLE;
                        n_wc             = 16'd0;
                        n_out.error_code = pdbr_pkg::ERR_SECOND_ACK;
                    end else begin
                        n_phase = PH_A2_LO;
                        n_wc    = r_strobe_ticks;
                    end
                end
            end
            PH_WAIT_HI3: begin
                if (req.busy_level) begin
                    n_pins[PIN_DIR] = 1'b1;
                    n_bc            = '0;
                    n_phase         = PH_D_HI;
                    n_wc            = 16'd0;
                end
            end
            default: begin
                if (r_wc > 16'd1) begin
                    n_wc = r_wc - 16'd1;
                end
            end
        endcase

        if (n_wc <= 16'd1) begin
            unique case (n_phase)
                PH_D_SETUP: begin
                    n_pins[PIN_DIR:PIN_CMD] = 3'b111;
                    n_phase = PH_D_LOWER;
                    n_wc    = r_settle_ticks;
                end
                PH_D_LOWER: begin
                    n_pins[PIN_CMD] = 1'b0;
                    n_pins[PIN_DIR] = 1'b1;
                    n_phase = PH_D_WAITLO;
                    n_wc    = r_settle_ticks;
                end
                PH_D_WAITLO: begin
                    n_phase = PH_WAIT_LO1;
                    n_wc    = 16'd0;
                end
                PH_D_READ1: begin
                    n_pins[PIN_STB] = 1'b0;
                    if (sampled != ACK_FIRST) begin
                        n_pins           = PIN_RESET;
                        n_phase          = PH_IDLE;
                        n_wc             = 16'd0;
                        n_out.error_code = pdbr_pkg::ERR_HANDSHAKE;
                    end else begin
                        n_phase = PH_A1_LO;
                        n_wc    = r_strobe_ticks;
                    end
                end
                PH_A1_LO: begin
                    n_pins[PIN_STB] = 1'b1;
                    n_phase = PH_A1_HI;
                    n_wc    = r_strobe_ticks;
                end
                PH_A1_HI: begin
                    n_pins[PIN_DIR] = 1'b0;
                    n_pins[11:3]    = pdbr_pkg::odd_frame(ANSWER);
                    n_phase = PH_D_CMDHI;
                    n_wc    = r_settle_ticks;
                end
                PH_D_CMDHI: begin
                    n_pins[PIN_CMD] = 1'b1;
                    n_phase = PH_D_WAITHI2;
                    n_wc    = r_settle_ticks;
                end
                PH_D_WAITHI2: begin
                    n_phase = PH_WAIT_HI2;
                    n_wc    = 16'd0;
                end
                PH_D_CMDS: begin
                    n_pins[PIN_STB] = 1'b1;
                    n_phase = PH_C_SETUP;
                    n_wc    = r_cmd_setup_ticks;
                end
                PH_C_SETUP: begin
                    n_pins[11:3] = pdbr_pkg::odd_frame(
                        f_command_byte(n_ci, n_addr, r_retry_count, r_spare_threshold));
                    n_phase = PH_C_DRIVE;
                    n_wc    = r_cmd_setup_ticks;
                end
                PH_C_DRIVE: begin
                    n_pins[PIN_STB] = 1'b0;
                    n_phase = PH_C_HOLD;
                    n_wc    = r_cmd_hold_ticks;
                end
                PH_C_HOLD: begin
                    n_ci = n_ci + 3'd1;
                    if (n_ci < CMD_COUNT) begin
                        n_pins[PIN_STB] = 1'b1;
                        n_phase = PH_C_SETUP;
                        n_wc    = r_cmd_setup_ticks;
                    end else begin
                        n_phase = PH_D_POSTCMD;
                        n_wc    = r_settle_ticks;
                    end
                end
                PH_D_POSTCMD: begin
                    n_pins[PIN_STB] = 1'b1;
                    n_phase = PH_D_RDBUS;
                    n_wc    = r_settle_ticks;
                end
                PH_D_RDBUS: begin
                    n_pins[PIN_DIR] = 1'b1;
                    n_phase = PH_D_CMDLO;
                    n_wc    = r_settle_ticks;
                end
                PH_D_CMDLO: begin
                    n_pins[PIN_CMD] = 1'b0;
                    n_phase = PH_WAIT_LO2;
                    n_wc    = 16'd0;
                end
                PH_A2_LO: begin
                    n_pins[PIN_STB] = 1'b1;
                    n_phase = PH_A2_HI;
                    n_wc    = r_strobe_ticks;
                end
                PH_A2_HI: begin
                    n_pins[PIN_DIR] = 1'b0;
                    n_pins[11:3]    = pdbr_pkg::odd_frame(ANSWER);
                    n_pins[PIN_CMD] = 1'b1;
                    n_phase = PH_WAIT_HI3;
                    n_wc    = 16'd0;
                end
                PH_D_LO: begin
                    n_pins[PIN_STB] = 1'b1;
                    n_phase = PH_D_HI;
                    n_wc    = r_strobe_ticks;
                end
                PH_D_HI: begin
                    if (n_bc >= pdbr_pkg::BLOCK_BYTES_C) begin
                        n_phase = PH_IDLE;
                        n_wc    = 16'd0;
                    end else begin
                        n_pins[PIN_STB] = 1'b0;
                        n_out.char_valid = 1'b1;
                        n_out.low_char   = CHAR_BASE + 7'(req.bus_data[3:0]);
                        n_out.high_char  = CHAR_BASE + 7'(sampled[8:4]);
                        n_bc = n_bc + BC_W'(1);
                        n_out.last_char  = (n_bc >= pdbr_pkg::BLOCK_BYTES_C);
                        n_phase = PH_D_LO;
                        n_wc    = r_strobe_ticks;
                    end
                end
                default: begin
                end
            endcase
        end

        n_out.cmd_line    = n_pins[PIN_CMD];
        n_out.strobe_line = n_pins[PIN_STB];
        n_out.dir_read    = n_pins[PIN_DIR];
        n_out.bus_out     = n_pins[10:3];
        n_out.parity_out  = n_pins[11];
        n_out.active      = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_wc        <= 16'd0;
            r_bc        <= '0;
            r_ci        <= 3'd0;
            r_addr      <= 16'd0;
            r_pins      <= PIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (req_accept) begin
                r_phase     <= n_phase;
                r_wc        <= n_wc;
                r_bc        <= n_bc;
                r_ci        <= n_ci;
                r_addr      <= n_addr;
                r_pins      <= n_pins;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_out <= n_out;
        end
    end

    assign pins_odd  = (r_pins[11] == ~^r_pins[10:3]);
    assign bc_ok     = (r_bc <= pdbr_pkg::BLOCK_BYTES_C);
    assign rsp_fault = r_out_valid && (r_out.error_code != pdbr_pkg::ERR_NONE);
    assign fault_ok  = !r_out.active && !r_out.char_valid && (r_phase == PH_IDLE);
    assign rsp_char  = r_out_valid && r_out.char_valid;
    assign char_ok   = r_out.dir_read && !r_out.strobe_line && r_out.active;
    assign rsp_last  = r_out_valid && r_out.last_char;
    assign last_ok   = r_out.char_valid && (r_bc == pdbr_pkg::BLOCK_BYTES_C);

    `PDBR_ASSERT_IMP(a_parity_odd, i_clk, i_rst_n, 1'b1, pins_odd, "bus parity is not odd")
    `PDBR_ASSERT_IMP(a_bc_range, i_clk, i_rst_n, 1'b1, bc_ok, "byte count past block end")
    `PDBR_ASSERT_IMP(a_err_idle, i_clk, i_rst_n, rsp_fault, fault_ok, "fault result while active")
    `PDBR_ASSERT_IMP(a_char_read, i_clk, i_rst_n, rsp_char, char_ok, "data character outside a read")
    `PDBR_ASSERT_IMP(a_last_char, i_clk, i_rst_n, rsp_last, last_ok, "last character flag misplaced")

endmodule

// ===== tb/pdbr_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbr_tb_pkg
// Line-level tracker of the block read host: it steps its own copy of the
// handshake sequencer for every accepted request and checks each result.
// ----------------------------------------------------------------------------
package pdbr_tb_pkg;

    typedef enum logic [4:0] {
        HS_IDLE, HS_WAIT_HI1, HS_SETUP, HS_LOWER, HS_WAITLO_PAUSE, HS_WAIT_LO1,
        HS_READ1, HS_ACK1_LO, HS_ACK1_HI, HS_CMD_HI, HS_WAITHI2_PAUSE, HS_WAIT_HI2,
        HS_CMDS, HS_CMD_SETUP, HS_CMD_DRIVE, HS_CMD_HOLD, HS_POST_CMD, HS_TURN_BUS,
        HS_CMD_LO, HS_WAIT_LO2, HS_ACK2_LO, HS_ACK2_HI, HS_WAIT_HI3, HS_DATA_LO,
        HS_DATA_HI
    } t_hs_phase;

    typedef enum logic [1:0] {
        RD_GOOD,
        RD_BAD_FIRST,
        RD_BAD_ACK
    } t_read_mode;

    localparam logic [8:0] FIRST_REPLY  = 9'h001;
    localparam logic [8:0] SECOND_REPLY = 9'h002;
    localparam logic [7:0] HOST_ANSWER  = 8'h55;
    localparam logic [6:0] CHAR_BASE    = 7'h40;
    localparam int         CMD_BYTES    = 6;

    class t_read_host_tracker;
        logic [15:0] strobe_ticks;
        logic [15:0] cmd_setup_ticks;
        logic [15:0] cmd_hold_ticks;
        logic [15:0] settle_ticks;
        logic [7:0]  retry_count;
        logic [7:0]  spare_threshold;

        t_hs_phase   phase;
        logic [15:0] wait_cnt;
        logic [9:0]  byte_cnt;
        logic [2:0]  cmd_idx;
        logic [15:0] addr_hold;
        logic        cmd_lvl;
        logic        stb_lvl;
        logic        dir_lvl;
        logic [7:0]  bus_lvl;
        logic        par_lvl;

        pdbr_pkg::t_rsp expected_lines[$];
        int unsigned    mismatch_count;

        function new();
            strobe_ticks    = 16'd5;
            cmd_setup_ticks = 16'd100;
            cmd_hold_ticks  = 16'd1000;
            settle_ticks    = 16'd2000;
            retry_count     = 8'd100;
            spare_threshold = 8'd20;
            phase           = HS_IDLE;
            wait_cnt        = '0;
            byte_cnt        = '0;
            cmd_idx         = '0;
            addr_hold       = '0;
            mismatch_count  = 0;
            restore_lines();
        endfunction

        function void restore_lines();
            cmd_lvl = 1'b1;
            stb_lvl = 1'b1;
            dir_lvl = 1'b1;
            bus_lvl = 8'h00;
            par_lvl = 1'b1;
        endfunction

        function void enter(t_hs_phase ph, logic [15:0] ticks);
            phase    = ph;
            wait_cnt = ticks;
        endfunction

        function void drive_byte(logic [7:0] value);
            bus_lvl = value;
            par_lvl = ~^value;
        endfunction

        function void set_register(logic [pdbr_pkg::CFG_IDX_W-1:0] idx,
                                   logic [pdbr_pkg::CFG_W-1:0] value);
            case (idx)
                pdbr_pkg::CFG_STROBE_TICKS:    strobe_ticks    = value;
                pdbr_pkg::CFG_CMD_SETUP_TICKS: cmd_setup_ticks = value;
                pdbr_pkg::CFG_CMD_HOLD_TICKS:  cmd_hold_ticks  = value;
                pdbr_pkg::CFG_SETTLE_TICKS:    settle_ticks    = value;
                pdbr_pkg::CFG_RETRY_COUNT:     retry_count     = value[7:0];
                pdbr_pkg::CFG_SPARE_THRESHOLD: spare_threshold = value[7:0];
                default: ;
            endcase
        endfunction

        function pdbr_pkg::t_rsp advance_tick(pdbr_pkg::t_req r);
            logic [8:0]     sampled;
            pdbr_pkg::t_rsp o;
            sampled = {r.bus_parity, r.bus_data};
            o = '0;
            o.error_code = pdbr_pkg::ERR_NONE;

            case (phase)
                HS_IDLE: begin
                    if (r.command == pdbr_pkg::CMD_START) begin
                        addr_hold = r.block_address;
                        enter(HS_WAIT_HI1, '0);
                    end
                end
                HS_WAIT_HI1: begin
                    if (r.busy_level) enter(HS_SETUP, settle_ticks);
                end
                HS_WAIT_LO1: begin
                    if (!r.busy_level) enter(HS_READ1, settle_ticks);
                end
                HS_WAIT_HI2: begin
                    if (r.busy_level) begin
                        cmd_idx = '0;
                        enter(HS_CMDS, settle_ticks);
                    end
                end
                HS_WAIT_LO2: begin
                    if (!r.busy_level) begin
                        stb_lvl = 1'b0;
                        if (sampled != SECOND_REPLY) begin
                            restore_lines();
                            enter(HS_IDLE, '0);
                            o.error_code = pdbr_pkg::ERR_SECOND_ACK;
                        end else begin
                            enter(HS_ACK2_LO, strobe_ticks);
                        end
                    end
                end
                HS_WAIT_HI3: begin
                    if (r.busy_level) begin
                        dir_lvl  = 1'b1;
                        byte_cnt = '0;
                        enter(HS_DATA_HI, '0);
                    end
                end
                default: begin
                    if (wait_cnt > 1) wait_cnt = wait_cnt - 1'b1;
                end
            endcase

            // A pause acts on its last tick; a zero length acts at once.
            if (wait_cnt <= 1) begin
                case (phase)
                    HS_SETUP: begin
                        cmd_lvl = 1'b1;
                        stb_lvl = 1'b1;
                        dir_lvl = 1'b1;
                        enter(HS_LOWER, settle_ticks);
                    end
                    HS_LOWER: begin
                        cmd_lvl = 1'b0;
                        dir_lvl = 1'b1;
                        enter(HS_WAITLO_PAUSE, settle_ticks);
                    end
                    HS_WAITLO_PAUSE: enter(HS_WAIT_LO1, '0);
                    HS_READ1: begin
                        stb_lvl = 1'b0;
                        if (sampled != FIRST_REPLY) begin
                            restore_lines();
                            enter(HS_IDLE, '0);
                            o.error_code = pdbr_pkg::ERR_HANDSHAKE;
                        end else begin
                            enter(HS_ACK1_LO, strobe_ticks);
                        end
                    end
                    HS_ACK1_LO: begin
                        stb_lvl = 1'b1;
                        enter(HS_ACK1_HI, strobe_ticks);
                    end
                    HS_ACK1_HI: begin
                        dir_lvl = 1'b0;
                        drive_byte(HOST_ANSWER);
                        enter(HS_CMD_HI, settle_ticks);
                    end
                    HS_CMD_HI: begin
                        cmd_lvl = 1'b1;
                        enter(HS_WAITHI2_PAUSE, settle_ticks);
                    end
                    HS_WAITHI2_PAUSE: enter(HS_WAIT_HI2, '0);
                    HS_CMDS: begin
                        stb_lvl = 1'b1;
                        enter(HS_CMD_SETUP, cmd_setup_ticks);
                    end
                    HS_CMD_SETUP: begin
                        case (cmd_idx)
                            3'd2:    drive_byte(addr_hold[15:8]);
                            3'd3:    drive_byte(addr_hold[7:0]);
                            3'd4:    drive_byte(retry_count);
                            3'd5:    drive_byte(spare_threshold);
                            default: drive_byte(8'h00);
                        endcase
                        enter(HS_CMD_DRIVE, cmd_setup_ticks);
                    end
                    HS_CMD_DRIVE: begin
                        stb_lvl = 1'b0;
                        enter(HS_CMD_HOLD, cmd_hold_ticks);
                    end
                    HS_CMD_HOLD: begin
                        cmd_idx = cmd_idx + 1'b1;
                        if (cmd_idx < CMD_BYTES) begin
                            stb_lvl = 1'b1;
                            enter(HS_CMD_SETUP, cmd_setup_ticks);
                        end else begin
                            enter(HS_POST_CMD, settle_ticks);
                        end
                    end
                    HS_POST_CMD: begin
                        stb_lvl = 1'b1;
                        enter(HS_TURN_BUS, settle_ticks);
                    end
                    HS_TURN_BUS: begin
                        dir_lvl = 1'b1;
                        enter(HS_CMD_LO, settle_ticks);
                    end
                    HS_CMD_LO: begin
                        cmd_lvl = 1'b0;
                        enter(HS_WAIT_LO2, '0);
                    end
                    HS_ACK2_LO: begin
                        stb_lvl = 1'b1;
                        enter(HS_ACK2_HI, strobe_ticks);
                    end
                    HS_ACK2_HI: begin
                        dir_lvl = 1'b0;
                        drive_byte(HOST_ANSWER);
                        cmd_lvl = 1'b1;
                        enter(HS_WAIT_HI3, '0);
                    end
                    HS_DATA_LO: begin
                        stb_lvl = 1'b1;
                        enter(HS_DATA_HI, strobe_ticks);
                    end
                    HS_DATA_HI: begin
                        if (byte_cnt >= pdbr_pkg::BLOCK_BYTES) begin
                            enter(HS_IDLE, '0);
                        end else begin
                            stb_lvl      = 1'b0;
                            o.char_valid = 1'b1;
                            o.low_char   = CHAR_BASE + r.bus_data[3:0];
                            o.high_char  = CHAR_BASE + sampled[8:4];
                            byte_cnt     = byte_cnt + 1'b1;
                            o.last_char  = (byte_cnt >= pdbr_pkg::BLOCK_BYTES);
                            enter(HS_DATA_LO, strobe_ticks);
                        end
                    end
                    default: ;
                endcase
            end

            o.cmd_line    = cmd_lvl;
            o.strobe_line = stb_lvl;
            o.dir_read    = dir_lvl;
            o.bus_out     = bus_lvl;
            o.parity_out  = par_lvl;
            o.active      = (phase != HS_IDLE);
            return o;
        endfunction

        function void note_request(pdbr_pkg::t_req r);
            expected_lines.push_back(advance_tick(r));
        endfunction

        function int unsigned pending();
            return expected_lines.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_response(pdbr_pkg::t_rsp got);
            pdbr_pkg::t_rsp want;
            if (expected_lines.size() == 0) begin
                $error("Result arrived with no request outstanding.");
                mismatch_count++;
                return;
            end
            want = expected_lines.pop_front();
            compare_field("cmd_line", want.cmd_line, got.cmd_line);
            compare_field("strobe_line", want.strobe_line, got.strobe_line);
            compare_field("dir_read", want.dir_read, got.dir_read);
            compare_field("bus_out", want.bus_out, got.bus_out);
            compare_field("parity_out", want.parity_out, got.parity_out);
            compare_field("char_valid", want.char_valid, got.char_valid);
            compare_field("low_char", want.low_char, got.low_char);
            compare_field("high_char", want.high_char, got.high_char);
            compare_field("last_char", want.last_char, got.last_char);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("active", want.active, got.active);
        endfunction
    endclass

endpackage

// ===== tb/parallel_disk_block_read_host_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_disk_block_read_host_tb
// Drives tick and start requests that play the drive side of the block read,
// with broken handshakes and noise mixed in, under several timing settings,
// and checks every line and character result against a tracked sequencer.
// ----------------------------------------------------------------------------
module parallel_disk_block_read_host_tb;

    localparam int unsigned WATCHDOG_LIMIT = 5000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_wr_en;
    logic [pdbr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pdbr_pkg::CFG_W-1:0]     cfg_data;

    pdbr_req_if req_ch ();
    pdbr_rsp_if rsp_ch ();

    pdbr_tb_pkg::t_read_host_tracker tracker;
    int unsigned      tx_gap_pct = 10;
    int unsigned      rx_gap_pct = 10;
    int unsigned      quiet_cycles = 0;
    int unsigned      gap_pcts[3] = '{0, 10, 30};

    parallel_disk_block_read_host i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic pdbr_pkg::t_req random_tick();
        pdbr_pkg::t_req r;
        r.command       = pdbr_pkg::CMD_TICK;
        r.block_address = 16'($urandom);
        r.busy_level    = 1'($urandom);
        r.bus_data      = 8'($urandom);
        r.bus_parity    = 1'($urandom);
        return r;
    endfunction

    function automatic logic [8:0] corrupt(input logic [8:0] good);
        logic [8:0] v;
        if ($urandom_range(0, 2) == 0) return good | 9'h100;
        do v = 9'($urandom); while (v == good);
        return v;
    endfunction

    // The drive side: busy and reply bytes follow the host's current step.
    function automatic pdbr_pkg::t_req next_tick(input pdbr_tb_pkg::t_read_mode mode,
                                                 input logic [8:0] bad_reply);
        pdbr_pkg::t_req r;
        r = random_tick();
        if ($urandom_range(0, 39) == 0) r.command = pdbr_pkg::CMD_START;
        case (tracker.phase)
            pdbr_tb_pkg::HS_WAIT_HI1, pdbr_tb_pkg::HS_WAIT_HI2,
            pdbr_tb_pkg::HS_WAIT_HI3: begin
                r.busy_level = ($urandom_range(0, 3) != 0);
            end
            pdbr_tb_pkg::HS_WAIT_LO1, pdbr_tb_pkg::HS_READ1: begin
                if (tracker.phase == pdbr_tb_pkg::HS_WAIT_LO1) begin
                    r.busy_level = ($urandom_range(0, 3) == 0);
                end
                {r.bus_parity, r.bus_data} = (mode == pdbr_tb_pkg::RD_BAD_FIRST) ?
                                             bad_reply : pdbr_tb_pkg::FIRST_REPLY;
            end
            pdbr_tb_pkg::HS_WAIT_LO2: begin
                r.busy_level = ($urandom_range(0, 3) == 0);
                {r.bus_parity, r.bus_data} = (mode == pdbr_tb_pkg::RD_BAD_ACK) ?
                                             bad_reply : pdbr_tb_pkg::SECOND_REPLY;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input pdbr_pkg::t_req r);
        int unsigned gap;
        gap = pick_gap(tx_gap_pct);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.payload = r;
        req_ch.valid   = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [pdbr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pdbr_pkg::CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        tracker.set_register(idx, value);
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(input logic [15:0] strobe, input logic [15:0] setup,
                             input logic [15:0] hold, input logic [15:0] settle,
                             input logic [7:0] retry, input logic [7:0] spare);
        wait_drained();
        write_register(pdbr_pkg::CFG_STROBE_TICKS, strobe);
        write_register(pdbr_pkg::CFG_CMD_SETUP_TICKS, setup);
        write_register(pdbr_pkg::CFG_CMD_HOLD_TICKS, hold);
        write_register(pdbr_pkg::CFG_SETTLE_TICKS, settle);
        write_register(pdbr_pkg::CFG_RETRY_COUNT, {8'h00, retry});
        write_register(pdbr_pkg::CFG_SPARE_THRESHOLD, {8'h00, spare});
    endtask

    task automatic send_idle_noise(input int unsigned count);
        repeat (count) send_request(random_tick());
    endtask

    task automatic run_read(input logic [15:0] addr, input pdbr_tb_pkg::t_read_mode mode,
                            input logic [8:0] bad_reply);
        pdbr_pkg::t_req r;
        r = random_tick();
        r.command       = pdbr_pkg::CMD_START;
        r.block_address = addr;
        send_request(r);
        while (tracker.phase != pdbr_tb_pkg::HS_IDLE) begin
            send_request(next_tick(mode, bad_reply));
        end
    endtask

    initial begin
        int unsigned hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                rsp_ch.ready = 1'b0;
                hold--;
            end else begin
                hold = pick_gap(rx_gap_pct);
                rsp_ch.ready = (hold == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) tracker.check_response(rsp_ch.payload);
            if (req_ch.valid && req_ch.ready) tracker.note_request(req_ch.payload);
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
                cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial begin
        pdbr_pkg::t_req          r;
        pdbr_tb_pkg::t_read_mode mode;
        int                      set_idx;
        int                      k;

        tracker        = new();
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: idle ticks at the field extremes, then one broken
        // handshake of each kind with the parity bit set on the reply.
        configure(16'd1, 16'd1, 16'd1, 16'd0, 8'h00, 8'hFF);
        r = '0;
        send_request(r);
        r = '1;
        r.command = pdbr_pkg::CMD_TICK;
        send_request(r);
        run_read(16'hFFFF, pdbr_tb_pkg::RD_BAD_FIRST, pdbr_tb_pkg::FIRST_REPLY | 9'h100);
        run_read(16'h0000, pdbr_tb_pkg::RD_BAD_ACK, pdbr_tb_pkg::SECOND_REPLY | 9'h100);

        // One full block read and one refused handshake at the shortest timings,
        // the rest refused handshakes under short random timings.
        for (set_idx = 0; set_idx < 3; set_idx++) begin
            if (set_idx == 0) begin
                configure(16'd1, 16'd1, 16'd1, 16'd1, 8'($urandom), 8'($urandom));
            end else begin
                configure(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                          16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                          8'($urandom), 8'($urandom));
            end
            for (k = 0; k < 2; k++) begin
                tx_gap_pct = gap_pcts[$urandom_range(0, 2)];
                rx_gap_pct = gap_pcts[$urandom_range(0, 2)];
                if ($urandom_range(0, 1) == 0) begin
                    mode = pdbr_tb_pkg::RD_BAD_FIRST;
                end else begin
                    mode = pdbr_tb_pkg::RD_BAD_ACK;
                end
                if (set_idx == 0 && k == 0) mode = pdbr_tb_pkg::RD_GOOD;
                send_idle_noise($urandom_range(0, 4));
                run_read(16'($urandom), mode,
                         corrupt((mode == pdbr_tb_pkg::RD_BAD_FIRST) ?
                                 pdbr_tb_pkg::FIRST_REPLY : pdbr_tb_pkg::SECOND_REPLY));
                if ($urandom_range(0, 2) == 0) wait_drained();
            end
        end

        // A longer settling pause, then a refused first handshake.
        tx_gap_pct = 2;
        rx_gap_pct = 2;
        configure(16'd1, 16'd1, 16'd1, 16'd20, 8'hFF, 8'h00);
        run_read(16'($urandom), pdbr_tb_pkg::RD_BAD_FIRST, corrupt(pdbr_tb_pkg::FIRST_REPLY));
        send_idle_noise(4);

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pdbr_pkg.sv
hdl/pdbr_req_if.sv
hdl/pdbr_rsp_if.sv
hdl/parallel_disk_block_read_host.sv
tb/pdbr_tb_pkg.sv
tb/parallel_disk_block_read_host_tb.sv
